>>> sv/krlc_pkg.sv
// Package for the key repeat level control block.
// Transaction types, key codes, register indexes and reset values.
// No dependencies.
package krlc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VOL_CEIL         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRI_CEIL         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLEEP_GAP        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME_START     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS_START = 3'd6;

  // register reset values
  localparam logic [7:0]  VOL_CEIL_RST         = 8'd20;
  localparam logic [7:0]  BRI_CEIL_RST         = 8'd10;
  localparam logic [15:0] REPEAT_DELAY_RST     = 16'd300;
  localparam logic [15:0] REPEAT_PERIOD_RST    = 16'd100;
  localparam logic [15:0] SLEEP_GAP_RST        = 16'd1000;
  localparam logic [7:0]  VOLUME_START_RST     = 8'd0;
  localparam logic [7:0]  BRIGHTNESS_START_RST = 8'd0;

  // item kinds and key decode
  localparam logic        KIND_KEY      = 1'b0;
  localparam logic        KIND_TICK     = 1'b1;
  localparam logic [15:0] EV_TYPE_KEY   = 16'd1;
  localparam logic [15:0] CODE_MENU_KEY = 16'd27;
  localparam logic [15:0] CODE_UP_KEY   = 16'd12;
  localparam logic [15:0] CODE_DOWN_KEY = 16'd11;
  localparam logic [31:0] KEY_VALUE_MAX = 32'd2;

  typedef struct packed {
    logic               kind;
    logic [15:0]        event_type;
    logic [15:0]        key_code;
    logic signed [31:0] key_value;
    logic [31:0]        now_ms;
  } in_item_t;

  typedef struct packed {
    logic [7:0] volume;
    logic [7:0] brightness;
    logic       changed;
  } out_item_t;

  // step request from key tracking to level stepping
  typedef struct packed {
    logic menu;
    logic up;
    logic down;
  } step_req_t;

endpackage

>>> sv/key_repeat_level_control_top.sv
// Top level of the key repeat level control block.
// Depends on krlc_pkg, krlc_keys and krlc_levels.
//
// Key events and poll ticks enter one transaction per clock. Each accepted
// transaction lands in an input register; from there the key tracker
// and the level stepper process it in one pass and a poll tick writes its
// result (volume, brightness, changed) into the output register, so out_valid
// rises once the tick leaves the input register. Key events give no result.
// Throughput is one transaction per cycle; the input side stalls
// only while a tick sits in the input register and the output register
// still holds a result that is not taken. Configuration writes land at
// once; a write to volume_start or brightness_start also reloads that level.
module key_repeat_level_control_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  krlc_pkg::in_item_t                    in_data,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output krlc_pkg::out_item_t                   out_data,
  // configuration writes
  input  logic                                  cfg_we,
  input  logic [krlc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [krlc_pkg::CFG_DATA_W-1:0]       cfg_data
);

  // configuration registers
  logic [7:0]  vol_ceil_r, bri_ceil_r;
  logic [15:0] repeat_delay_r, repeat_period_r, sleep_gap_r;
  logic        load_volume, load_brightness;

  // input register stage
  krlc_pkg::in_item_t  s1_r;
  logic                s1_valid_r;
  logic                s1_go;
  logic                s1_tick;
  logic                in_take;

  // output register stage
  krlc_pkg::out_item_t out_r;
  logic                out_valid_r;
  logic                out_room;

  krlc_pkg::step_req_t req;
  krlc_pkg::out_item_t lvl_res;

  assign load_volume     = cfg_we && (cfg_index == krlc_pkg::REG_VOLUME_START);
  assign load_brightness = cfg_we && (cfg_index == krlc_pkg::REG_BRIGHTNESS_START);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vol_ceil_r      <= krlc_pkg::VOL_CEIL_RST;
      bri_ceil_r      <= krlc_pkg::BRI_CEIL_RST;
      repeat_delay_r  <= krlc_pkg::REPEAT_DELAY_RST;
      repeat_period_r <= krlc_pkg::REPEAT_PERIOD_RST;
      sleep_gap_r     <= krlc_pkg::SLEEP_GAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        krlc_pkg::REG_VOL_CEIL:      vol_ceil_r      <= cfg_data[7:0];
        krlc_pkg::REG_BRI_CEIL:      bri_ceil_r      <= cfg_data[7:0];
        krlc_pkg::REG_REPEAT_DELAY:  repeat_delay_r  <= cfg_data;
        krlc_pkg::REG_REPEAT_PERIOD: repeat_period_r <= cfg_data;
        krlc_pkg::REG_SLEEP_GAP:     sleep_gap_r     <= cfg_data;
        default: ; // start values live in the level stepper
      endcase
    end
  end

  // Stage 1 advances unless it holds a tick and the output is blocked.
  assign s1_tick  = s1_valid_r && (s1_r.kind == krlc_pkg::KIND_TICK);
  assign out_room = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && ((s1_r.kind == krlc_pkg::KIND_KEY) || out_room);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_take || (s1_valid_r && !s1_go);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_r <= in_data;
    end
  end

  krlc_keys u_keys (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_en       (s1_go),
    .item          (s1_r),
    .repeat_delay  (repeat_delay_r),
    .repeat_period (repeat_period_r),
    .sleep_gap     (sleep_gap_r),
    .req           (req)
  );

  krlc_levels u_levels (
    .clk             (clk),
    .rst_n           (rst_n),
    .step_en         (s1_go && s1_tick),
    .req             (req),
    .vol_ceil        (vol_ceil_r),
    .bri_ceil        (bri_ceil_r),
    .load_volume     (load_volume),
    .load_brightness (load_brightness),
    .load_value      (cfg_data[7:0]),
    .res             (lvl_res)
  );

  // output register: a tick's result loads whenever the slot frees up
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_tick) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_tick) begin
      out_r <= lvl_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  // every tick that leaves stage 1 shows up as a result
  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_tick |=> out_valid_r)
    else $error("tick transaction produced no result");

  // a key event never produces a result
  a_key_silent: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && !s1_tick && (!out_valid_r || !out_stall) |=> !out_valid_r)
    else $error("key event produced a result");

  // stage 1 only stalls on a tick facing a blocked output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_tick && out_valid_r && out_stall)
    else $error("input stalled without cause");
`endif

endmodule

>>> sv/krlc_keys.sv
// Key tracking for the key repeat level control block: held/fresh/armed
// flags, repeat due times, sleep gap detection. Uses krlc_pkg.
module krlc_keys (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_en,
  input  krlc_pkg::in_item_t  item,
  input  logic [15:0]         repeat_delay,
  input  logic [15:0]         repeat_period,
  input  logic [15:0]         sleep_gap,
  output krlc_pkg::step_req_t req
);

  logic        menu_held_r, menu_held_nxt;
  logic        up_held_r, up_held_nxt, up_fresh_r, up_fresh_nxt, up_armed_r, up_armed_nxt;
  logic        dn_held_r, dn_held_nxt, dn_fresh_r, dn_fresh_nxt, dn_armed_r, dn_armed_nxt;
  logic [31:0] up_due_r, up_due_nxt, dn_due_r, dn_due_nxt;
  logic [31:0] last_tick_r, last_tick_nxt;
  logic        started_r, started_nxt;

  logic        key_ok, key_on;
  logic [31:0] now, gap;
  logic        asleep;
  logic [31:0] up_due_c, dn_due_c;
  logic        menu_c, up_held_c, up_fresh_c, dn_held_c, dn_fresh_c;
  logic        up_go, dn_go;

  always_comb begin
    now    = item.now_ms;
    key_ok = (item.event_type == krlc_pkg::EV_TYPE_KEY) &&
             ($unsigned(item.key_value) <= krlc_pkg::KEY_VALUE_MAX);
    key_on = (item.key_value != 32'sd0);

    gap    = now - last_tick_r;
    asleep = started_r && (gap > {16'd0, sleep_gap});

    // arming happens before the sleep clear, which then wipes it
    up_due_c   = asleep ? 32'd0 : (up_armed_r ? now + {16'd0, repeat_delay} : up_due_r);
    dn_due_c   = asleep ? 32'd0 : (dn_armed_r ? now + {16'd0, repeat_delay} : dn_due_r);
    menu_c     = menu_held_r && !asleep;
    up_held_c  = up_held_r && !asleep;
    up_fresh_c = up_fresh_r && !asleep;
    dn_held_c  = dn_held_r && !asleep;
    dn_fresh_c = dn_fresh_r && !asleep;

    up_go = up_fresh_c || (up_held_c && (now >= up_due_c));
    dn_go = dn_fresh_c || (dn_held_c && (now >= dn_due_c));

    req.menu = menu_c;
    req.up   = up_go;
    req.down = dn_go;

    menu_held_nxt = menu_held_r;
    up_held_nxt   = up_held_r;
    up_fresh_nxt  = up_fresh_r;
    up_armed_nxt  = up_armed_r;
    up_due_nxt    = up_due_r;
    dn_held_nxt   = dn_held_r;
    dn_fresh_nxt  = dn_fresh_r;
    dn_armed_nxt  = dn_armed_r;
    dn_due_nxt    = dn_due_r;
    last_tick_nxt = last_tick_r;
    started_nxt   = started_r;

    if (item.kind == krlc_pkg::KIND_TICK) begin
      menu_held_nxt = menu_c;
      up_held_nxt   = up_held_c;
      up_fresh_nxt  = 1'b0;
      up_armed_nxt  = 1'b0;
      up_due_nxt    = (up_go && !up_fresh_c) ? up_due_c + {16'd0, repeat_period} : up_due_c;
      dn_held_nxt   = dn_held_c;
      dn_fresh_nxt  = 1'b0;
      dn_armed_nxt  = 1'b0;
      dn_due_nxt    = (dn_go && !dn_fresh_c) ? dn_due_c + {16'd0, repeat_period} : dn_due_c;
      last_tick_nxt = now;
      started_nxt   = 1'b1;
    end else if (key_ok) begin
      if (item.key_code == krlc_pkg::CODE_MENU_KEY) begin
        menu_held_nxt = key_on;
      end else if (item.key_code == krlc_pkg::CODE_UP_KEY) begin
        up_held_nxt  = key_on;
        up_fresh_nxt = key_on;
        up_armed_nxt = up_armed_r || key_on;
      end else if (item.key_code == krlc_pkg::CODE_DOWN_KEY) begin
        dn_held_nxt  = key_on;
        dn_fresh_nxt = key_on;
        dn_armed_nxt = dn_armed_r || key_on;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      menu_held_r <= 1'b0;
      up_held_r   <= 1'b0;
      up_fresh_r  <= 1'b0;
      up_armed_r  <= 1'b0;
      up_due_r    <= 32'd0;
      dn_held_r   <= 1'b0;
      dn_fresh_r  <= 1'b0;
      dn_armed_r  <= 1'b0;
      dn_due_r    <= 32'd0;
      last_tick_r <= 32'd0;
      started_r   <= 1'b0;
    end else if (item_en) begin
      menu_held_r <= menu_held_nxt;
      up_held_r   <= up_held_nxt;
      up_fresh_r  <= up_fresh_nxt;
      up_armed_r  <= up_armed_nxt;
      up_due_r    <= up_due_nxt;
      dn_held_r   <= dn_held_nxt;
      dn_fresh_r  <= dn_fresh_nxt;
      dn_armed_r  <= dn_armed_nxt;
      dn_due_r    <= dn_due_nxt;
      last_tick_r <= last_tick_nxt;
      started_r   <= started_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // a fresh up key steps on the tick that follows unless the sleep gap has passed
  a_fresh_steps: assert property (@(posedge clk) disable iff (!rst_n)
    item_en && item.kind == krlc_pkg::KIND_TICK && up_fresh_r && !asleep |-> req.up)
    else $error("fresh up key did not step");

  // after any tick nothing is left fresh or armed
  a_tick_clears: assert property (@(posedge clk) disable iff (!rst_n)
    item_en && item.kind == krlc_pkg::KIND_TICK
    |=> !up_fresh_r && !dn_fresh_r && !up_armed_r && !dn_armed_r && started_r)
    else $error("tick left key state pending");

  // a sleep gap blocks every step
  a_sleep_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    asleep |-> !req.up && !req.down && !req.menu)
    else $error("step requested across sleep gap");
`endif

endmodule

>>> sv/krlc_levels.sv
// Volume and brightness levels for the key repeat level control block:
// saturating up/down steps and start-value loads. Uses krlc_pkg.
module krlc_levels (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  krlc_pkg::step_req_t  req,
  input  logic [7:0]           vol_ceil,
  input  logic [7:0]           bri_ceil,
  input  logic                 load_volume,
  input  logic                 load_brightness,
  input  logic [7:0]           load_value,
  output krlc_pkg::out_item_t  res
);

  logic [7:0] volume_r, volume_nxt, brightness_r, brightness_nxt;
  logic [7:0] lvl, top, lvl_up, lvl_dn;
  logic       up_ok, dn_ok;

  always_comb begin
    lvl    = req.menu ? brightness_r : volume_r;
    top    = req.menu ? bri_ceil : vol_ceil;
    // plus first, minus sees its result
    up_ok  = req.up && (lvl < top);
    lvl_up = up_ok ? lvl + 8'd1 : lvl;
    dn_ok  = req.down && (lvl_up != 8'd0);
    lvl_dn = dn_ok ? lvl_up - 8'd1 : lvl_up;

    volume_nxt     = req.menu ? volume_r : lvl_dn;
    brightness_nxt = req.menu ? lvl_dn : brightness_r;

    res.volume     = volume_nxt;
    res.brightness = brightness_nxt;
    res.changed    = up_ok || dn_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volume_r     <= krlc_pkg::VOLUME_START_RST;
      brightness_r <= krlc_pkg::BRIGHTNESS_START_RST;
    end else if (load_volume || load_brightness) begin
      if (load_volume) begin
        volume_r <= load_value;
      end
      if (load_brightness) begin
        brightness_r <= load_value;
      end
    end else if (step_en) begin
      volume_r     <= volume_nxt;
      brightness_r <= brightness_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // a level moves by at most one per tick
  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && !load_volume && !load_brightness
    |=> ($past(volume_r) == volume_r || $past(volume_r) + 8'd1 == volume_r ||
         $past(volume_r) - 8'd1 == volume_r))
    else $error("volume moved by more than one");

  // only the selected level moves
  a_menu_select: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && req.menu |-> res.volume == volume_r)
    else $error("volume moved while menu held");

  // no change reported means levels held
  a_changed_flag: assert property (@(posedge clk) disable iff (!rst_n)
    !res.changed |-> res.volume == volume_r && res.brightness == brightness_r)
    else $error("level moved without change flag");
`endif

endmodule
